FILE: design/pwtm_pkg.sv
// Shared constants and types for the pulse width trimmed mean block.
package pwtm_pkg;

  localparam int TIME_W      = 16;
  localparam int SAMPLES_DEF = 16;
  localparam int QUOT_W      = 16;

  typedef struct packed {
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: design/pwtm_cell.sv
// One cell of the insertion sorting chain: holds one width, passes the larger one on.
module pwtm_cell import pwtm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  logic              tok_in_valid,
  input  logic [TIME_W-1:0] tok_in,
  input  logic [TIME_W-1:0] shift_in,
  output logic              tok_out_valid,
  output logic [TIME_W-1:0] tok_out,
  output logic [TIME_W-1:0] value
);

  logic occupied;
  logic keep_new;

  // The cell keeps the smaller of its own and the incoming width.
  assign keep_new = (tok_in < value);

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied      <= 1'b0;
      tok_out_valid <= 1'b0;
    end else if (ctrl.shift) begin
      value         <= shift_in;
      occupied      <= 1'b0;
      tok_out_valid <= 1'b0;
    end else begin
      tok_out_valid <= 1'b0;
      if (tok_in_valid) begin
        if (!occupied) begin
          value    <= tok_in;
          occupied <= 1'b1;
        end else begin
          value         <= keep_new ? tok_in : value;
          tok_out       <= keep_new ? value : tok_in;
          tok_out_valid <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/pwtm_divider.sv
// Divider by a fixed divisor, built as a reciprocal multiplication with a registered operand and a registered quotient.
module pwtm_divider import pwtm_pkg::*; #(
  parameter int ACC_W   = 20,
  parameter int DIVISOR = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [ACC_W-1:0]  dividend,
  output logic              done,
  output logic [QUOT_W-1:0] quotient
);

  // With SHIFT = ACC_W + ceil(log2(DIVISOR)) and RECIP = ceil(2^SHIFT / DIVISOR), the
  // top bits of dividend * RECIP give the exact floor quotient for any ACC_W-bit dividend.
  localparam int     SHIFT   = ACC_W + $clog2(DIVISOR);
  localparam int     RECIP_W = ACC_W + 1;
  localparam int     PROD_W  = ACC_W + RECIP_W;
  localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(DIVISOR - 1))
                               / longint'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  logic [ACC_W-1:0]  num;
  logic [PROD_W-1:0] prod;
  logic              loaded;

  assign prod = PROD_W'(num) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
      done   <= 1'b0;
    end else begin
      loaded <= go;
      done   <= loaded;
    end
    if (go) begin
      num <= dividend;
    end
    if (loaded) begin
      quotient <= prod[SHIFT +: QUOT_W];
    end
  end

endmodule

FILE: design/pulse_width_trimmed_mean_core.sv
// Top level of the pulse width trimmed mean block: edge pairing, sorting chain and control.
//
// Usage: capture_time carries a timer timestamp; a request is taken at a rising clock
// edge where start is high and busy is low. Requests alternate between a rising and a
// falling signal edge, the first after reset being a rising one. A rising-edge request
// only records the timestamp and busy stays low, so the next request may follow in the
// next cycle. A falling-edge request forms the width (difference modulo 2^16) and feeds
// it into a chain of SAMPLES sorting cells; it ripples one cell per cycle, and busy stays
// high while it settles along the chain.
// Once SAMPLES widths are held, the chain is shifted out in ascending order while the
// middle third is summed, then the sum is divided by the size of the middle third with
// a reciprocal multiplication. valid is then high for one cycle with mean_width, and the
// window starts again empty. For the request that completes a window, busy drops at
// the edge that takes the result, so the next request can be taken in the next cycle.
// Reset (synchronous, rst high) empties the window and expects a rising edge next.
// The receiver cannot stall: each result is shown for exactly one cycle.
module pulse_width_trimmed_mean_core import pwtm_pkg::*; #(
  parameter int SAMPLES = SAMPLES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [TIME_W-1:0] capture_time,
  output logic              valid,
  output logic [TIME_W-1:0] mean_width
);

  localparam int TRIM_LO  = SAMPLES / 3;
  localparam int TRIM_HI  = (SAMPLES * 2) / 3;
  localparam int TRIM_CNT = TRIM_HI - TRIM_LO;
  localparam int CNT_W    = $clog2(SAMPLES + 1);
  localparam int ACC_W    = TIME_W + $clog2(SAMPLES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_DRAIN,
    ST_DIV_GO,
    ST_DIV_WAIT
  } state_t;

  state_t            state;
  logic              expect_falling;
  logic [TIME_W-1:0] start_time;
  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  cnt;
  logic [ACC_W-1:0]  acc;

  logic              accept;
  logic              falling_req;
  cell_ctrl_t        ctrl;

  // Chain links: entry i feeds cell i; the extra entry is the spill of the last cell,
  // which never carries a token since the chain is never overfilled.
  logic              tok_valid [SAMPLES+1];
  logic [TIME_W-1:0] tok       [SAMPLES+1];
  logic [TIME_W-1:0] cell_val  [SAMPLES];

  logic              div_done;
  logic [QUOT_W-1:0] div_quot;

  assign busy        = (state != ST_IDLE);
  assign accept      = start && !busy;
  assign falling_req = accept && expect_falling;
  assign ctrl.shift  = (state == ST_DRAIN);

  // A falling edge enters the chain at cell 0 in the same cycle it is taken.
  assign tok_valid[0] = falling_req;
  assign tok[0]       = capture_time - start_time;

  for (genvar i = 0; i < SAMPLES; i++) begin : g_chain
    logic [TIME_W-1:0] right_val;
    if (i == SAMPLES - 1) begin : g_end
      assign right_val = '0;
    end else begin : g_mid
      assign right_val = cell_val[i+1];
    end
    pwtm_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .tok_in_valid (tok_valid[i]),
      .tok_in       (tok[i]),
      .shift_in     (right_val),
      .tok_out_valid(tok_valid[i+1]),
      .tok_out      (tok[i+1]),
      .value        (cell_val[i])
    );
  end

  pwtm_divider #(
    .ACC_W  (ACC_W),
    .DIVISOR(TRIM_CNT)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .go      (state == ST_DIV_GO),
    .dividend(acc),
    .done    (div_done),
    .quotient(div_quot)
  );

  assign valid      = div_done;
  assign mean_width = div_quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      expect_falling <= 1'b0;
      start_time     <= '0;
      fill_count     <= '0;
      cnt            <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            expect_falling <= !expect_falling;
            if (!expect_falling) begin
              start_time <= capture_time;
            end else begin
              fill_count <= fill_count + CNT_W'(1);
              cnt        <= '0;
              state      <= ST_INSERT;
            end
          end
        end
        ST_INSERT: begin
          // Wait until the new width has settled anywhere along the chain.
          if (cnt == CNT_W'(SAMPLES - 2)) begin
            cnt <= '0;
            acc <= '0;
            if (fill_count == CNT_W'(SAMPLES)) begin
              state <= ST_DRAIN;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_DRAIN: begin
          // Cell 0 shows the widths in ascending order, one per cycle.
          if (cnt >= CNT_W'(TRIM_LO)) begin
            acc <= acc + ACC_W'(cell_val[0]);
          end
          if (cnt == CNT_W'(TRIM_HI - 1)) begin
            fill_count <= '0;
            state      <= ST_DIV_GO;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_DIV_GO: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sim/pulse_width_mean_checker.sv
// Checker that pairs capture requests into widths, predicts each trimmed mean and compares results.
module pulse_width_mean_checker import pwtm_pkg::*; #(
  parameter int SAMPLES = SAMPLES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [TIME_W-1:0] capture_time,
  input  logic              valid,
  input  logic [TIME_W-1:0] mean_width,
  output int                fail_count,
  output int                means_awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEEP_LO = SAMPLES / 3;
  localparam int KEEP_HI = (2 * SAMPLES) / 3;

  typedef logic [TIME_W-1:0] window_t [SAMPLES];

  logic              falling_next;
  logic [TIME_W-1:0] rise_stamp;
  window_t           widths;
  int                held;
  logic [QUOT_W-1:0] expected_means [$];

  initial begin
    fail_count    = 0;
    means_awaited = 0;
    falling_next  = 1'b0;
    rise_stamp    = '0;
    held          = 0;
  end

  // Sorts a copy of the window and averages the middle third with a wide sum.
  function automatic logic [QUOT_W-1:0] trimmed_mean_of(input window_t w);
    window_t           s;
    logic [TIME_W-1:0] key;
    logic [31:0]       total;
    int                j;
    s     = w;
    total = '0;
    for (int i = 1; i < SAMPLES; i++) begin
      key = s[i];
      j   = i - 1;
      while (j >= 0 && s[j] > key) begin
        s[j + 1] = s[j];
        j--;
      end
      s[j + 1] = key;
    end
    for (int i = KEEP_LO; i < KEEP_HI; i++) total += 32'(s[i]);
    return QUOT_W'(total / 32'(KEEP_HI - KEEP_LO));
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    logic [QUOT_W-1:0] wanted;
    if (rst) begin
      falling_next = 1'b0;
      rise_stamp   = '0;
      held         = 0;
      expected_means.delete();
    end else begin
      if (valid) begin
        if (expected_means.size() == 0) begin
          note_failure($sformatf("mean_width %0d arrived with no window pending", mean_width));
        end else begin
          wanted = expected_means.pop_front();
          if (mean_width !== wanted)
            note_failure($sformatf("mean_width mismatch: expected %0d, got %0d",
                                   wanted, mean_width));
        end
      end
      if (start && !busy) begin
        if (!falling_next) begin
          rise_stamp = capture_time;
        end else begin
          widths[held] = capture_time - rise_stamp;
          held++;
          if (held == SAMPLES) begin
            expected_means.push_back(trimmed_mean_of(widths));
            held = 0;
          end
        end
        falling_next = !falling_next;
      end
    end
    means_awaited = expected_means.size();
  end

endmodule

FILE: sim/pulse_width_trimmed_mean_core_tb.sv
// Testbench top for the pulse width trimmed mean block: stimulus, timeout and verdict.
module pulse_width_trimmed_mean_core_tb import pwtm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // The block is exercised at its default window size, so every window is sixteen
  // rising/falling request pairs and one mean per window comes back.
  localparam int SAMPLES        = SAMPLES_DEF;
  localparam int RANDOM_WINDOWS = 28;
  localparam int QUIET_WINDOWS  = 4;
  localparam int DRAIN_CYCLES   = 120;
  localparam int CYCLE_LIMIT    = 400000;

  // The way the widths of one window are chosen. Equal, rising and falling runs
  // stress the sorting chain with ties and with already ordered or reversed input.
  typedef enum int {
    WIDTHS_ANY,
    WIDTHS_SHORT,
    WIDTHS_LONG,
    WIDTHS_EQUAL,
    WIDTHS_RISING,
    WIDTHS_FALLING
  } width_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [TIME_W-1:0] capture_time = '0;
  logic              valid;
  logic [TIME_W-1:0] mean_width;
  int                fail_count;
  int                means_awaited;
  int                cycle_count = 0;

  // The directed window: each entry holds the rising timestamp in its upper half and
  // the falling one in its lower half. It covers zero widths, the largest width, the
  // timer wrapping between the rising and the falling stamp, and both extreme timestamps.
  logic [31:0] directed_edges [SAMPLES_DEF] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_FFFF,
    32'hFFF0_0010, 32'h8000_7FFF, 32'h5555_AAAA, 32'hAAAA_5555,
    32'h1234_1334, 32'h7FFF_8000, 32'hFFFF_0000, 32'h0100_0200,
    32'h4000_C000, 32'hC000_4000, 32'h00FF_0FFF, 32'hF00F_F10F
  };

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pulse_width_trimmed_mean_core #(
    .SAMPLES(SAMPLES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .capture_time (capture_time),
    .valid        (valid),
    .mean_width   (mean_width)
  );

  pulse_width_mean_checker #(
    .SAMPLES(SAMPLES)
  ) checker_inst (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .capture_time  (capture_time),
    .valid         (valid),
    .mean_width    (mean_width),
    .fail_count    (fail_count),
    .means_awaited (means_awaited)
  );

  // Presents one request at the falling edge and holds it until a rising edge finds
  // busy low. busy is read straight after the rising edge, before the block's own
  // updates land, so it is the value the block itself saw. start is left high, so a
  // following request can be taken in the very next cycle.
  task automatic issue_request(input logic [TIME_W-1:0] stamp);
    @(negedge clk);
    start        <= 1'b1;
    capture_time <= stamp;
    do @(posedge clk); while (busy);
  endtask

  // Now and then the sender drops start and goes quiet, which lands the next request
  // on whatever phase of sorting or dividing is under way.
  task automatic maybe_idle(input bit enabled);
    if (enabled && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
    end
  endtask

  function automatic logic [TIME_W-1:0] pick_width(input width_mode_t mode, input int idx,
                                                   input logic [TIME_W-1:0] base);
    case (mode)
      WIDTHS_SHORT:   return TIME_W'($urandom_range(0, 15));
      WIDTHS_LONG:    return TIME_W'($urandom_range(65520, 65535));
      WIDTHS_EQUAL:   return base;
      WIDTHS_RISING:  return base + TIME_W'(idx * 97);
      WIDTHS_FALLING: return base - TIME_W'(idx * 97);
      default:        return TIME_W'($urandom);
    endcase
  endfunction

  // A hung block must not leave the run going for ever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pulse_width_trimmed_mean_core regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [TIME_W-1:0] rise_at;
    logic [TIME_W-1:0] base;
    width_mode_t       mode;
    bit                idling;

    // Synchronous reset held from the start, released on a falling edge.
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed window, sent back to back so that requests meet busy head on.
    foreach (directed_edges[k]) begin
      issue_request(directed_edges[k][31:16]);
      issue_request(directed_edges[k][15:0]);
    end

    // Random windows. Every request sequence is well formed by construction, since
    // the block only pairs edges; the content of each window is what varies. The first
    // two windows are all largest and all zero widths, giving the extreme means.
    for (int w = 0; w < RANDOM_WINDOWS; w++) begin
      if (w == 0) begin
        mode = WIDTHS_EQUAL;
        base = '1;
      end else if (w == 1) begin
        mode = WIDTHS_EQUAL;
        base = '0;
      end else begin
        mode = width_mode_t'($urandom_range(0, 5));
        base = TIME_W'($urandom);
      end
      // Some windows run without any idling, and the closing windows never idle.
      idling = (w < RANDOM_WINDOWS - QUIET_WINDOWS) && ($urandom_range(0, 2) != 0);

      // Halfway through, the sender holds off until every pending mean has come back,
      // so the next window starts on an entirely quiet block.
      if (w == RANDOM_WINDOWS / 2) begin
        @(negedge clk);
        start <= 1'b0;
        wait (means_awaited == 0);
      end

      for (int p = 0; p < SAMPLES; p++) begin
        rise_at = TIME_W'($urandom);
        issue_request(rise_at);
        maybe_idle(idling);
        issue_request(rise_at + pick_width(mode, p, base));
        maybe_idle(idling);
      end
    end

    @(negedge clk);
    start <= 1'b0;

    // Let the last window drain, then give the block time to show any stray result.
    wait (means_awaited == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && means_awaited == 0) begin
      $display("pulse_width_trimmed_mean_core regression: pass");
    end else begin
      $display("pulse_width_trimmed_mean_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
design/pwtm_pkg.sv
design/pwtm_cell.sv
design/pwtm_divider.sv
design/pulse_width_trimmed_mean_core.sv
sim/pulse_width_mean_checker.sv
sim/pulse_width_trimmed_mean_core_tb.sv
